>>> src/ecd_pkg.sv
package ecd_pkg;

  // field widths
  localparam int FloorW   = 6;
  localparam int KindW    = 2;
  localparam int NoiseW   = 6;
  localparam int RssiW    = 8;
  localparam int PendW    = 8;
  localparam int CntW     = 32;
  localparam int FlagW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int InDataW  = 32;
  localparam int OutDataW = 96;

  // default number of served floors
  localparam int FloorsDef = 30;

  // register reset values
  localparam logic signed [RssiW-1:0] RssiBaseRst  = -8'sd50;
  localparam logic signed [RssiW-1:0] ClearThrRst  = -8'sd70;
  localparam logic signed [RssiW-1:0] RssiLimitRst = -8'sd120;

  // event codes, code 7 is a no-op
  typedef enum logic [2:0] {
    OP_TOGGLE   = 3'd0,
    OP_PLACE    = 3'd1,
    OP_CLR_FLR  = 3'd2,
    OP_CLR_ALL  = 3'd3,
    OP_MOVE     = 3'd4,
    OP_DISPATCH = 3'd5,
    OP_AUTO     = 3'd6
  } op_e;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RSSI_BASE = 2'd0,
    CFG_CLEAR_THR = 2'd1,
    CFG_RSSI_LIM  = 2'd2
  } cfg_idx_e;

  localparam logic [KindW-1:0] KindLoad = 2'd2;

  typedef struct packed {
    logic signed [RssiW-1:0] rssi_base;
    logic signed [RssiW-1:0] clear_threshold;
    logic signed [RssiW-1:0] rssi_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic [FloorW-1:0]        floor;
    logic [KindW-1:0]         call_kind;
    logic signed [NoiseW-1:0] noise_up;
    logic signed [NoiseW-1:0] noise_down;
    logic signed [NoiseW-1:0] noise_load;
  } item_t;

  typedef struct packed {
    logic [FloorW-1:0] car_floor;
    logic [FloorW-1:0] goal_floor;
    logic              car_moving;
    logic              auto_on;
    logic [PendW-1:0]  pending_count;
    logic [CntW-1:0]   calls_placed;
    logic [CntW-1:0]   cleared_by_arrival;
    logic [FlagW-1:0]  floor_flags;
    logic [FlagW-1:0]  arrival_cleared_mask;
    logic              dispatched;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_start;
    logic scan_rd;
    logic scan_end;
    logic rd_item;
    logic modify;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       dispatch_go;
    logic       scan_last;
  } sts_t;

  // number of set bits in a flag triple
  function automatic logic [1:0] flag_count(input logic [FlagW-1:0] f);
    flag_count = {1'b0, f[0]} + {1'b0, f[1]} + {1'b0, f[2]};
  endfunction

endpackage

>>> src/ecd_ctrl.sv
module ecd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  input  ecd_pkg::sts_t     sts_i,
  output ecd_pkg::cmd_t     cmd_o
);
  import ecd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SDRAIN = 3'd3;
  localparam logic [2:0] S_SEND   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_MOD    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.op == OP_DISPATCH && sts_i.dispatch_go) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          state_d = S_READ;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = S_SDRAIN;
      end
      S_SDRAIN: state_d = S_SEND;
      S_SEND: begin
        cmd_o.scan_end = 1'b1;
        state_d        = S_READ;
      end
      S_READ: begin
        cmd_o.rd_item = 1'b1;
        state_d       = S_MOD;
      end
      S_MOD: begin
        cmd_o.modify = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/ecd_datapath.sv
module ecd_datapath #(
  parameter int FLOORS = ecd_pkg::FloorsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ecd_pkg::cfg_t  cfg_i,
  input  ecd_pkg::item_t item_i,
  input  ecd_pkg::cmd_t  cmd_i,
  output ecd_pkg::sts_t  sts_o,
  output ecd_pkg::res_t  res_o
);
  import ecd_pkg::*;

  localparam int Depth = FLOORS + 1;
  localparam int AddrW = $clog2(Depth);
  localparam logic [FloorW-1:0] TopFloor = FloorW'(FLOORS);

  // call flag store, entry 0 is never written
  logic [FlagW-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;

  item_t             item_q;
  logic [FloorW-1:0] cur_q, tgt_q;
  logic              moving_q, auto_q, stepped_q;
  logic [PendW-1:0]  pend_q;
  logic [CntW-1:0]   placed_q, acnt_q;
  logic [FlagW-1:0]  flags_q, mask_q;
  logic              disp_q;

  // scan state
  logic [FloorW-1:0] scan_idx_q, best_q;
  logic [FloorW:0]   bestd_q;
  logic              scan_vld_q;

  // read port
  logic [FloorW-1:0] rd_addr, rd_addr_q;
  logic              rd_en, rd_hit_q;
  logic [FlagW-1:0]  rd_data_q, rd_flags;

  logic              floor_ok, kind_ok;
  logic [FlagW-1:0]  kind_bit, new_flags, clr_mask;
  logic              wr_en;
  logic [1:0]        drop_cnt;
  logic              add_one;
  logic [FloorW-1:0] floor_gap;

  assign floor_ok = (item_q.floor != '0) && (item_q.floor <= TopFloor);
  assign kind_ok  = item_q.call_kind <= KindLoad;
  assign kind_bit = FlagW'(1) << item_q.call_kind;

  assign sts_o.op          = item_q.opcode;
  assign sts_o.dispatch_go = auto_q && !moving_q;
  assign sts_o.scan_last   = scan_idx_q == TopFloor;

  // read address select
  always_comb begin
    rd_en   = cmd_i.scan_rd || cmd_i.rd_item;
    rd_addr = cur_q;
    if (cmd_i.scan_rd) begin
      rd_addr = scan_idx_q;
    end else if (item_q.opcode == OP_TOGGLE || item_q.opcode == OP_PLACE ||
                 item_q.opcode == OP_CLR_FLR) begin
      rd_addr = item_q.floor;
    end
  end

  // registered memory read
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr[AddrW-1:0]];
      rd_addr_q <= rd_addr;
      rd_hit_q  <= (rd_addr <= TopFloor) && valid_q[rd_addr[AddrW-1:0]];
    end
  end

  assign rd_flags = rd_hit_q ? rd_data_q : '0;

  // signal level test for each call kind
  function automatic logic sig_above(input logic signed [NoiseW-1:0] n, input cfg_t c);
    logic signed [RssiW:0] sig;
    logic signed [RssiW:0] lim;
    sig = {c.rssi_base[RssiW-1], c.rssi_base} + {{(RssiW-NoiseW+1){n[NoiseW-1]}}, n};
    lim = {c.rssi_limit[RssiW-1], c.rssi_limit};
    if (sig < lim) sig = lim;
    sig_above = sig > $signed({c.clear_threshold[RssiW-1], c.clear_threshold});
  endfunction

  // flag update for call ops and arrival
  always_comb begin
    new_flags = rd_flags;
    clr_mask  = '0;
    wr_en     = 1'b0;
    drop_cnt  = '0;
    add_one   = 1'b0;
    case (item_q.opcode)
      OP_TOGGLE, OP_PLACE: begin
        if (floor_ok && kind_ok) begin
          if ((rd_flags & kind_bit) != '0) begin
            if (item_q.opcode == OP_TOGGLE) begin
              new_flags = rd_flags & ~kind_bit;
              drop_cnt  = 2'd1;
              wr_en     = 1'b1;
            end
          end else begin
            new_flags = rd_flags | kind_bit;
            add_one   = 1'b1;
            wr_en     = 1'b1;
          end
        end
      end
      OP_CLR_FLR: begin
        if (floor_ok) begin
          new_flags = '0;
          drop_cnt  = flag_count(rd_flags);
          wr_en     = 1'b1;
        end
      end
      OP_MOVE: begin
        if (stepped_q) begin
          clr_mask  = rd_flags & {sig_above(item_q.noise_load, cfg_i),
                                  sig_above(item_q.noise_down, cfg_i),
                                  sig_above(item_q.noise_up, cfg_i)};
          new_flags = rd_flags & ~clr_mask;
          drop_cnt  = flag_count(clr_mask);
          wr_en     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memory write
  always_ff @(posedge clk_i) begin
    if (cmd_i.modify && wr_en) begin
      mem_q[rd_addr_q[AddrW-1:0]] <= new_flags;
    end
  end

  // per-entry valid bits, clear-all drops them at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.exec && item_q.opcode == OP_CLR_ALL) begin
      valid_q <= '0;
    end else if (cmd_i.modify && wr_en) begin
      valid_q[rd_addr_q[AddrW-1:0]] <= 1'b1;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= item_i;
  end

  assign floor_gap = (rd_addr_q > cur_q) ? rd_addr_q - cur_q : cur_q - rd_addr_q;

  // car state, counters and scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= FloorW'(1);
      tgt_q      <= FloorW'(1);
      moving_q   <= 1'b0;
      auto_q     <= 1'b0;
      stepped_q  <= 1'b0;
      pend_q     <= '0;
      placed_q   <= '0;
      acnt_q     <= '0;
      flags_q    <= '0;
      mask_q     <= '0;
      disp_q     <= 1'b0;
      scan_idx_q <= '0;
      best_q     <= '0;
      bestd_q    <= '0;
      scan_vld_q <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.scan_rd;
      if (cmd_i.latch) begin
        stepped_q <= 1'b0;
        mask_q    <= '0;
        disp_q    <= 1'b0;
      end
      // event work done in the exec state
      if (cmd_i.exec) begin
        case (item_q.opcode)
          OP_CLR_ALL: pend_q <= '0;
          OP_MOVE: begin
            if (!moving_q || cur_q == tgt_q) begin
              moving_q <= 1'b0;
            end else begin
              stepped_q <= 1'b1;
              cur_q     <= (cur_q < tgt_q) ? cur_q + FloorW'(1) : cur_q - FloorW'(1);
            end
          end
          OP_AUTO: begin
            auto_q <= !auto_q;
            if (auto_q) moving_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.scan_start) begin
        scan_idx_q <= FloorW'(1);
        best_q     <= '0;
        bestd_q    <= '1;
      end
      if (cmd_i.scan_rd) scan_idx_q <= scan_idx_q + FloorW'(1);
      // nearest floor with a call, lowest wins ties
      if (scan_vld_q && rd_flags != '0 && {1'b0, floor_gap} < bestd_q) begin
        best_q  <= rd_addr_q;
        bestd_q <= {1'b0, floor_gap};
      end
      if (cmd_i.scan_end && best_q != '0) begin
        tgt_q    <= best_q;
        moving_q <= 1'b1;
        disp_q   <= 1'b1;
      end
      if (cmd_i.modify) begin
        flags_q  <= new_flags;
        mask_q   <= clr_mask;
        pend_q   <= pend_q - PendW'(drop_cnt) + PendW'(add_one);
        placed_q <= placed_q + CntW'(add_one);
        acnt_q   <= acnt_q + CntW'(item_q.opcode == OP_MOVE ? drop_cnt : 2'd0);
      end
    end
  end

  always_comb begin
    res_o.car_floor            = cur_q;
    res_o.goal_floor           = tgt_q;
    res_o.car_moving           = moving_q;
    res_o.auto_on              = auto_q;
    res_o.pending_count        = pend_q;
    res_o.calls_placed         = placed_q;
    res_o.cleared_by_arrival   = acnt_q;
    res_o.floor_flags          = flags_q;
    res_o.arrival_cleared_mask = mask_q;
    res_o.dispatched           = disp_q;
  end

endmodule

>>> src/elevator_call_dispatcher_core.sv
// channel   direction  transaction
// s_axis    in         one event: opcode, floor, call kind, three noise values
// m_axis    out        one status result per event
// cfg       in         register write, no read-back
//
// an event is accepted in the idle state and then passes through the exec,
// read, modify and output states; a dispatch tick in auto mode with the car
// idle also scans every floor in turn on the single read port of the call flag
// store. reset clears all call flags at once through per-floor valid bits, so
// no clearing pass is needed. the next event is accepted while the previous
// result waits in the output register; a result that is not taken holds the
// controller before loading the next one.
module elevator_call_dispatcher_core #(
  parameter int FLOORS = ecd_pkg::FloorsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // opcode, floor, call_kind, noise_up, noise_down, noise_load, pad
  input  logic [ecd_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // car_floor, goal_floor, car_moving, auto_on, pending_count, calls_placed,
  // cleared_by_arrival, floor_flags, arrival_cleared_mask, dispatched, pad
  output logic [ecd_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [ecd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ecd_pkg::RssiW-1:0]      cfg_wdata_i
);
  import ecd_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  cmd_t  cmd;
  sts_t  sts;
  res_t  res, out_q;
  logic  out_valid_q, out_free;

  // input unpack
  assign item.opcode     = s_axis_tdata[2:0];
  assign item.floor      = s_axis_tdata[8:3];
  assign item.call_kind  = s_axis_tdata[10:9];
  assign item.noise_up   = s_axis_tdata[16:11];
  assign item.noise_down = s_axis_tdata[22:17];
  assign item.noise_load = s_axis_tdata[28:23];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rssi_base       <= RssiBaseRst;
      cfg_q.clear_threshold <= ClearThrRst;
      cfg_q.rssi_limit      <= RssiLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RSSI_BASE: cfg_q.rssi_base       <= cfg_wdata_i;
        CFG_CLEAR_THR: cfg_q.clear_threshold <= cfg_wdata_i;
        CFG_RSSI_LIM:  cfg_q.rssi_limit      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ecd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ecd_datapath #(
    .FLOORS (FLOORS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .item_i (item),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  // output register
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.dispatched, out_q.arrival_cleared_mask,
                          out_q.floor_flags, out_q.cleared_by_arrival,
                          out_q.calls_placed, out_q.pending_count, out_q.auto_on,
                          out_q.car_moving, out_q.goal_floor, out_q.car_floor};

  // checks
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.pending_count <= PendW'(3 * FLOORS))
    else $error("pending count above flag capacity");

  a_move_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.car_moving |-> res.auto_on)
    else $error("car moving with auto mode off");

  a_car_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.car_floor != '0 && res.car_floor <= FloorW'(FLOORS))
    else $error("car floor out of range");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an event is in work");

endmodule

>>> test/ecd_status_checker.sv
`timescale 1ns / 100ps

module ecd_status_checker #(
  parameter int FLOORS = ecd_pkg::FloorsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         ev_valid_i,
  input  logic                         ev_ready_i,
  // opcode, floor, call_kind, noise_up, noise_down, noise_load, pad
  input  logic [ecd_pkg::InDataW-1:0]  ev_data_i,
  input  logic                         st_valid_i,
  input  logic                         st_ready_i,
  // car_floor, goal_floor, car_moving, auto_on, pending_count, calls_placed,
  // cleared_by_arrival, floor_flags, arrival_cleared_mask, dispatched, pad
  input  logic [ecd_pkg::OutDataW-1:0] st_data_i,
  input  logic                         cfg_we_i,
  input  logic [ecd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ecd_pkg::RssiW-1:0]    cfg_wdata_i,
  output int                           fail_count_o,
  output int                           outstanding_o,
  output int                           checked_o,
  output int                           dispatch_seen_o,
  output int                           arrival_clears_o
);
  import ecd_pkg::*;

  // shadow copy of the car and call state
  logic [FlagW-1:0]  flag_mem [64];
  logic [FloorW-1:0] car_pos;
  logic [FloorW-1:0] car_goal;
  logic              car_run;
  logic              auto_en;
  logic [PendW-1:0]  pend_calls;
  logic [CntW-1:0]   placed_cnt;
  logic [CntW-1:0]   arrival_cnt;
  cfg_t              cfg_q;

  // status words still owed by the block, oldest first
  res_t status_expected [$];

  function automatic logic floor_valid(input logic [FloorW-1:0] fl);
    return (fl >= 1) && (int'(fl) <= FLOORS);
  endfunction

  task automatic drop_call(input int fl, input int k);
    if (flag_mem[fl][k]) begin
      flag_mem[fl][k] = 1'b0;
      pend_calls = pend_calls - 1'b1;
    end
  endtask

  task automatic add_call(input int fl, input int k);
    if (!flag_mem[fl][k]) begin
      flag_mem[fl][k] = 1'b1;
      placed_cnt = placed_cnt + 1'b1;
      pend_calls = pend_calls + 1'b1;
    end
  endtask

  // advance the shadow state by one event and build its status word
  task automatic apply_event(input logic [InDataW-1:0] d, output res_t r);
    logic [2:0]        op;
    logic [FloorW-1:0] fl;
    logic [KindW-1:0]  kd;
    int                noise [3];
    logic [FlagW-1:0]  cleared;
    logic              disp;
    int                sig;
    int                best;
    int                bestd;
    int                gap;
    op       = d[2:0];
    fl       = d[8:3];
    kd       = d[10:9];
    noise[0] = int'($signed(d[16:11]));
    noise[1] = int'($signed(d[22:17]));
    noise[2] = int'($signed(d[28:23]));
    cleared  = '0;
    disp     = 1'b0;
    case (op)
      OP_TOGGLE: begin
        if (floor_valid(fl) && kd <= KindLoad) begin
          if (flag_mem[fl][kd]) drop_call(fl, kd);
          else add_call(fl, kd);
        end
      end
      OP_PLACE: begin
        if (floor_valid(fl) && kd <= KindLoad) add_call(fl, kd);
      end
      OP_CLR_FLR: begin
        if (floor_valid(fl)) begin
          for (int k = 0; k < 3; k++) drop_call(fl, k);
        end
      end
      OP_CLR_ALL: begin
        for (int i = 1; i <= FLOORS; i++) begin
          for (int k = 0; k < 3; k++) drop_call(i, k);
        end
      end
      OP_MOVE: begin
        if (!car_run || car_pos == car_goal) begin
          car_run = 1'b0;
        end else begin
          if (car_pos < car_goal) car_pos = car_pos + 1'b1;
          else car_pos = car_pos - 1'b1;
          // auto-clear on arrival when the clamped signal beats the threshold
          for (int k = 0; k < 3; k++) begin
            if (flag_mem[car_pos][k]) begin
              sig = int'(cfg_q.rssi_base) + noise[k];
              if (sig < int'(cfg_q.rssi_limit)) sig = int'(cfg_q.rssi_limit);
              if (sig > int'(cfg_q.clear_threshold)) begin
                drop_call(car_pos, k);
                arrival_cnt = arrival_cnt + 1'b1;
                cleared[k] = 1'b1;
              end
            end
          end
        end
      end
      OP_DISPATCH: begin
        if (auto_en && !car_run) begin
          best  = 0;
          bestd = 1000;
          // nearest floor with any call, lowest wins a tie
          for (int i = 1; i <= FLOORS; i++) begin
            if (flag_mem[i] != '0) begin
              gap = (i > int'(car_pos)) ? i - int'(car_pos) : int'(car_pos) - i;
              if (gap < bestd) begin
                bestd = gap;
                best  = i;
              end
            end
          end
          if (best > 0) begin
            car_goal = best[FloorW-1:0];
            car_run  = 1'b1;
            disp     = 1'b1;
          end
        end
      end
      OP_AUTO: begin
        auto_en = !auto_en;
        if (!auto_en) car_run = 1'b0;
      end
      default: ;
    endcase
    r.car_floor          = car_pos;
    r.goal_floor         = car_goal;
    r.car_moving         = car_run;
    r.auto_on            = auto_en;
    r.pending_count      = pend_calls;
    r.calls_placed       = placed_cnt;
    r.cleared_by_arrival = arrival_cnt;
    if (op == OP_TOGGLE || op == OP_PLACE || op == OP_CLR_FLR)
      r.floor_flags = floor_valid(fl) ? flag_mem[fl] : '0;
    else
      r.floor_flags = flag_mem[car_pos];
    r.arrival_cleared_mask = cleared;
    r.dispatched           = disp;
  endtask

  function automatic res_t unpack_status(input logic [OutDataW-1:0] t);
    res_t r;
    r.car_floor            = t[5:0];
    r.goal_floor           = t[11:6];
    r.car_moving           = t[12];
    r.auto_on              = t[13];
    r.pending_count        = t[21:14];
    r.calls_placed         = t[53:22];
    r.cleared_by_arrival   = t[85:54];
    r.floor_flags          = t[88:86];
    r.arrival_cleared_mask = t[91:89];
    r.dispatched           = t[92];
    return r;
  endfunction

  task automatic show_status(input string tag, input res_t s);
    $write("  %s car=%0d goal=%0d moving=%0b auto=%0b pending=%0d",
           tag, s.car_floor, s.goal_floor, s.car_moving, s.auto_on, s.pending_count);
    $display(" placed=%0d cleared=%0d flags=%03b mask=%03b disp=%0b",
             s.calls_placed, s.cleared_by_arrival, s.floor_flags, s.arrival_cleared_mask,
             s.dispatched);
  endtask

  // compare every field of a status word with the oldest expectation
  task automatic check_status(input res_t got);
    res_t want;
    logic bad;
    if (status_expected.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("[%0t] status transaction with nothing expected", $time);
        show_status("got ", got);
      end
    end else begin
      want = status_expected.pop_front();
      bad = (got.car_floor != want.car_floor) ||
            (got.goal_floor != want.goal_floor) ||
            (got.car_moving != want.car_moving) ||
            (got.auto_on != want.auto_on) ||
            (got.pending_count != want.pending_count) ||
            (got.calls_placed != want.calls_placed) ||
            (got.cleared_by_arrival != want.cleared_by_arrival) ||
            (got.floor_flags != want.floor_flags) ||
            (got.arrival_cleared_mask != want.arrival_cleared_mask) ||
            (got.dispatched != want.dispatched);
      if (bad) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("[%0t] status mismatch on result %0d", $time, checked_o);
          show_status("want", want);
          show_status("got ", got);
        end
      end
    end
    checked_o++;
    if (got.dispatched) dispatch_seen_o++;
    if (got.arrival_cleared_mask != '0) arrival_clears_o++;
  endtask

  // sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t nxt;
    if (!rst_ni) begin
      for (int i = 0; i < 64; i++) flag_mem[i] = '0;
      car_pos          = 6'd1;
      car_goal         = 6'd1;
      car_run          = 1'b0;
      auto_en          = 1'b0;
      pend_calls       = '0;
      placed_cnt       = '0;
      arrival_cnt      = '0;
      cfg_q.rssi_base       = RssiBaseRst;
      cfg_q.clear_threshold = ClearThrRst;
      cfg_q.rssi_limit      = RssiLimitRst;
      status_expected.delete();
      fail_count_o     = 0;
      checked_o        = 0;
      dispatch_seen_o  = 0;
      arrival_clears_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RSSI_BASE: cfg_q.rssi_base       = cfg_wdata_i;
          CFG_CLEAR_THR: cfg_q.clear_threshold = cfg_wdata_i;
          CFG_RSSI_LIM:  cfg_q.rssi_limit      = cfg_wdata_i;
          default: ;
        endcase
      end
      // a result can never belong to the event accepted at the same edge
      if (st_valid_i && st_ready_i) check_status(unpack_status(st_data_i));
      if (ev_valid_i && ev_ready_i) begin
        apply_event(ev_data_i, nxt);
        status_expected.push_back(nxt);
      end
    end
    outstanding_o = status_expected.size();
  end

endmodule

>>> test/tb_elevator_call_dispatcher_core.sv
`timescale 1ns / 100ps

module tb_elevator_call_dispatcher_core;
  import ecd_pkg::*;

  localparam int         NumFloors     = FloorsDef;
  localparam int         TotalEvents   = 1450;
  localparam int         NumPhases     = 6;
  localparam int         WatchdogLimit = 4000;
  localparam int         LongHold      = 300;
  localparam logic [2:0] OpNop         = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [RssiW-1:0]    cfg_wdata_i;

  int fail_count;
  int outstanding;
  int checked;
  int dispatch_seen;
  int arrival_clears;

  // traffic shaping, the receiver knobs change only right after a rising edge
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_len;
  int hold_req;
  int events_sent;
  bit auto_guess;
  int quiet_cycles;

  elevator_call_dispatcher_core #(
    .FLOORS(NumFloors)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  ecd_status_checker #(
    .FLOORS(NumFloors)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ev_valid_i       (s_axis_tvalid),
    .ev_ready_i       (s_axis_tready),
    .ev_data_i        (s_axis_tdata),
    .st_valid_i       (m_axis_tvalid),
    .st_ready_i       (m_axis_tready),
    .st_data_i        (m_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .checked_o        (checked),
    .dispatch_seen_o  (dispatch_seen),
    .arrival_clears_o (arrival_clears)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    int hold_seen;
    hold_left     = 0;
    hold_seen     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one event transaction, entered and left at a falling edge
  task automatic send_event(input logic [2:0] op, input int fl, input int kd,
                            input int nu, input int nd, input int nl);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {3'b000, nl[5:0], nd[5:0], nu[5:0], kd[1:0], fl[5:0], op};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    events_sent++;
    if (op == OP_AUTO) auto_guess = !auto_guess;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val[RssiW-1:0];
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic set_rx(input int pct, input bit long_hold);
    @(posedge clk_i);
    rx_stall_pct = pct;
    if (long_hold) begin
      hold_len = LongHold;
      hold_req++;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // edge cases first: bad floors and kinds, repeats, dispatch corners, auto off
  task automatic directed_events();
    send_event(OP_PLACE, 0, 0, 0, 0, 0);
    send_event(OP_TOGGLE, NumFloors + 1, 1, 0, 0, 0);
    send_event(OP_CLR_FLR, 63, 0, 0, 0, 0);
    send_event(OP_PLACE, 1, 3, 0, 0, 0);
    send_event(OP_TOGGLE, NumFloors, 3, 0, 0, 0);
    send_event(OP_TOGGLE, 1, 0, 0, 0, 0);
    send_event(OP_TOGGLE, 1, 0, 0, 0, 0);
    send_event(OP_PLACE, NumFloors, 2, 0, 0, 0);
    send_event(OP_PLACE, NumFloors, 2, 0, 0, 0);
    send_event(OP_CLR_FLR, NumFloors, 0, 0, 0, 0);
    send_event(OpNop, 63, 3, -1, -1, -1);
    send_event(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_event(OP_AUTO, 0, 0, 0, 0, 0);
    send_event(OP_DISPATCH, 0, 0, 0, 0, 0);
    // call at the car's own floor
    send_event(OP_PLACE, 1, 1, 0, 0, 0);
    send_event(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_event(OP_MOVE, 0, 0, 31, 31, 31);
    send_event(OP_CLR_FLR, 1, 0, 0, 0, 0);
    // trip with one call above, one at and one below the threshold
    send_event(OP_PLACE, 3, 0, 0, 0, 0);
    send_event(OP_PLACE, 3, 1, 0, 0, 0);
    send_event(OP_PLACE, 3, 2, 0, 0, 0);
    send_event(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_event(OP_MOVE, 0, 0, 0, 0, 0);
    send_event(OP_MOVE, 0, 0, 31, -32, -20);
    send_event(OP_MOVE, 0, 0, 0, 0, 0);
    // auto off while moving, then clear everything
    send_event(OP_PLACE, 5, 0, 0, 0, 0);
    send_event(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_event(OP_MOVE, 0, 0, -32, -32, -32);
    send_event(OP_AUTO, 0, 0, 0, 0, 0);
    send_event(OP_CLR_ALL, 0, 0, 0, 0, 0);
  endtask

  // calls, a dispatch and a run of move ticks with random noise
  task automatic run_trip();
    int n_calls;
    int n_moves;
    if (!auto_guess && $urandom_range(7) != 0) send_event(OP_AUTO, 0, 0, 0, 0, 0);
    n_calls = $urandom_range(1, 4);
    for (int k = 0; k < n_calls; k++) begin
      send_event(($urandom_range(3) == 0) ? OP_TOGGLE : OP_PLACE,
                 $urandom_range(1, NumFloors), $urandom_range(2),
                 $urandom_range(63), $urandom_range(63), $urandom_range(63));
    end
    send_event(OP_DISPATCH, $urandom_range(63), $urandom_range(3), 0, 0, 0);
    n_moves = $urandom_range(1, 14);
    for (int k = 0; k < n_moves; k++) begin
      if ($urandom_range(7) == 0) begin
        send_event(OP_PLACE, $urandom_range(1, NumFloors), $urandom_range(2),
                   $urandom_range(63), $urandom_range(63), $urandom_range(63));
      end
      send_event(OP_MOVE, $urandom_range(63), $urandom_range(3),
                 $urandom_range(63), $urandom_range(63), $urandom_range(63));
    end
  endtask

  // any opcode with any field values
  task automatic run_noise();
    send_event(3'($urandom_range(7)), $urandom_range(63), $urandom_range(3),
               $urandom_range(63), $urandom_range(63), $urandom_range(63));
  endtask

  function automatic int rand_level();
    return -int'($urandom_range(128));
  endfunction

  // stimulus and verdict
  initial begin
    int base_v;
    int thr_v;
    int lim_v;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_RSSI_BASE;
    cfg_wdata_i   = '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_len      = 0;
    hold_req      = 0;
    events_sent   = 0;
    auto_guess    = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_events();

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      // register setting per phase, reset values first, then extremes, then random levels
      case (p)
        0: begin base_v = -50;  thr_v = -70;  lim_v = -120; end
        1: begin base_v = 0;    thr_v = -128; lim_v = -128; end
        2: begin base_v = -128; thr_v = 0;    lim_v = -128; end
        3: begin base_v = -128; thr_v = -128; lim_v = 0;    end
        default: begin
          base_v = rand_level();
          thr_v  = rand_level();
          lim_v  = rand_level();
        end
      endcase
      write_reg(CFG_RSSI_BASE, base_v);
      write_reg(CFG_CLEAR_THR, thr_v);
      write_reg(CFG_RSSI_LIM, lim_v);
      // idling profile per phase, the long hold-off fills the block
      case (p)
        1:       begin tx_idle_pct = 67; set_rx(0, 1'b0);  end
        2:       begin tx_idle_pct = 0;  set_rx(67, 1'b0); end
        3:       begin tx_idle_pct = 22; set_rx(22, 1'b0); end
        4:       begin tx_idle_pct = 0;  set_rx(0, 1'b1);  end
        default: begin tx_idle_pct = 0;  set_rx(0, 1'b0);  end
      endcase
      while (events_sent < (p + 1) * TotalEvents / NumPhases) begin
        if ($urandom_range(3) != 0) run_trip();
        else run_noise();
      end
    end

    // drain and let the block settle
    tx_idle_pct = 0;
    wait_drained();
    set_rx(0, 1'b0);
    repeat (NumFloors + 16) @(negedge clk_i);

    $display("run covered %0d events under %0d register settings, %0d status results checked",
             events_sent, NumPhases, checked);
    $display("%0d dispatches chose a target, %0d results reported arrival clears",
             dispatch_seen, arrival_clears);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, outstanding);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
